>>> design/bdq_pkg.sv
// ----------------------------------------------------------------------------
// bdq_pkg: shared types and codes of the bounded deque
// Action codes, internal command encoding, status codes and the command
// record that travels from the front part to the back part.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bdq_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned ACT_W  = 3;
  localparam int unsigned STAT_W = 2;

  // action codes as they arrive on the input channel
  localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [ACT_W-1:0] ACT_PUSH_BACK  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_POP_BACK   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_LIST       = 3'd4;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT,
    OP_PUSH_BACK,
    OP_POP_FRONT,
    OP_POP_BACK,
    OP_LIST
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } stat_e;

  typedef enum logic {
    ST_CMD,
    ST_LIST
  } st_e;

  typedef struct packed {
    op_e               op;
    logic [DATA_W-1:0] value;
  } cmd_t;

  // result waiting for the store read data
  typedef struct packed {
    logic  from_mem;
    stat_e status;
    logic  last;
  } res_t;

endpackage

`default_nettype wire

>>> design/bdq_front.sv
// ----------------------------------------------------------------------------
// bdq_front: input side of the bounded deque
// Accepts items, decodes the action into a command and drops undefined
// actions, which cause no result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bdq_front (
  input  wire logic                       s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  wire logic [bdq_pkg::DATA_W-1:0] s_axis_tdata_i,  // value_in[31:0]
  input  wire logic [bdq_pkg::ACT_W-1:0]  s_axis_tuser_i,  // action[2:0]
  input  wire logic                       q_full_i,
  output logic                            q_push_o,
  output bdq_pkg::cmd_t                   q_cmd_o
);

  import bdq_pkg::*;

  logic act_known;

  // decode the action
  always_comb begin
    act_known = 1'b1;
    q_cmd_o.value = s_axis_tdata_i;
    q_cmd_o.op = OP_PUSH_FRONT;
    case (s_axis_tuser_i)
      ACT_PUSH_FRONT: q_cmd_o.op = OP_PUSH_FRONT;
      ACT_PUSH_BACK:  q_cmd_o.op = OP_PUSH_BACK;
      ACT_POP_FRONT:  q_cmd_o.op = OP_POP_FRONT;
      ACT_POP_BACK:   q_cmd_o.op = OP_POP_BACK;
      ACT_LIST:       q_cmd_o.op = OP_LIST;
      default:        act_known = 1'b0;
    endcase
  end

  // accept while the queue has room; drop unknown actions
  assign s_axis_tready_o = !q_full_i;
  assign q_push_o = s_axis_tvalid_i && !q_full_i && act_known;

endmodule

`default_nettype wire

>>> design/bdq_cmd_fifo.sv
// ----------------------------------------------------------------------------
// bdq_cmd_fifo: command queue between front and back
// Two-entry queue that lets the input side and the store side stall
// independently.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bdq_cmd_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire bdq_pkg::cmd_t push_data_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               valid_o,
  output bdq_pkg::cmd_t      data_o
);

  import bdq_pkg::*;

  cmd_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;
  logic       do_push, do_pop;

  assign full_o  = (fill_q == 2'd2);
  assign valid_o = (fill_q != 2'd0);
  assign data_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // advance pointers and fill level
  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q;
    if (do_push && !do_pop) begin
      fill_d = fill_q + 2'd1;
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // store the incoming command
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

>>> design/bdq_back.sv
// ----------------------------------------------------------------------------
// bdq_back: store side of the bounded deque
// Holds the ring store, front pointer and entry count, carries out the
// commands, walks the store for a listing and drives the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bdq_back #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cmd_valid_i,
  input  wire bdq_pkg::cmd_t              cmd_i,
  output logic                            cmd_ready_o,
  output logic                            m_axis_tvalid_o,
  input  wire logic                       m_axis_tready_i,
  output logic [bdq_pkg::DATA_W-1:0]      m_axis_tdata_o,  // value_out[31:0]
  output logic [bdq_pkg::STAT_W-1:0]      m_axis_tuser_o,  // status[1:0]
  output logic                            m_axis_tlast_o
);

  import bdq_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W = CNT_W + 1;

  // ring index of base + off, with base < DEPTH and off <= DEPTH
  function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(off);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

  function automatic logic [PTR_W-1:0] ring_dec(input logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_W'(DEPTH - 1) : p - PTR_W'(1);
  endfunction

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_q;

  st_e               state_q, state_d;
  logic [PTR_W-1:0]  front_q, front_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [PTR_W-1:0]  walk_q, walk_d;
  logic [CNT_W-1:0]  left_q, left_d;

  logic              pend_valid_q, pend_valid_d;
  res_t              pend_q, pend_d;

  logic              out_valid_q;
  logic [DATA_W-1:0] out_data_q;
  stat_e             out_stat_q;
  logic              out_last_q;

  logic              out_free, advance;
  logic              mem_we, mem_re;
  logic [PTR_W-1:0]  mem_addr;
  logic              is_full, is_empty;

  assign out_free = !out_valid_q || m_axis_tready_i;
  assign advance  = !pend_valid_q || out_free;
  assign is_full  = (count_q == CNT_W'(DEPTH));
  assign is_empty = (count_q == '0);

  // next state: carry out one command or one step of a listing
  always_comb begin
    state_d      = state_q;
    front_d      = front_q;
    count_d      = count_q;
    walk_d       = walk_q;
    left_d       = left_q;
    pend_valid_d = pend_valid_q && !out_free;
    pend_d       = pend_q;
    cmd_ready_o  = 1'b0;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_addr     = front_q;
    case (state_q)
      ST_CMD: begin
        cmd_ready_o = advance;
        if (cmd_valid_i && advance) begin
          pend_valid_d    = 1'b1;
          pend_d.from_mem = 1'b0;
          pend_d.status   = STAT_OK;
          pend_d.last     = 1'b1;
          case (cmd_i.op)
            OP_PUSH_FRONT: begin
              if (is_full) begin
                pend_d.status = STAT_FULL;
              end else begin
                front_d  = ring_dec(front_q);
                mem_addr = ring_dec(front_q);
                mem_we   = 1'b1;
                count_d  = count_q + CNT_W'(1);
              end
            end
            OP_PUSH_BACK: begin
              if (is_full) begin
                pend_d.status = STAT_FULL;
              end else begin
                mem_addr = ring_add(front_q, count_q);
                mem_we   = 1'b1;
                count_d  = count_q + CNT_W'(1);
              end
            end
            OP_POP_FRONT: begin
              if (is_empty) begin
                pend_d.status = STAT_EMPTY;
              end else begin
                mem_addr        = front_q;
                mem_re          = 1'b1;
                pend_d.from_mem = 1'b1;
                front_d         = ring_add(front_q, CNT_W'(1));
                count_d         = count_q - CNT_W'(1);
              end
            end
            OP_POP_BACK: begin
              if (is_empty) begin
                pend_d.status = STAT_EMPTY;
              end else begin
                mem_addr        = ring_add(front_q, count_q - CNT_W'(1));
                mem_re          = 1'b1;
                pend_d.from_mem = 1'b1;
                count_d         = count_q - CNT_W'(1);
              end
            end
            OP_LIST: begin
              if (is_empty) begin
                pend_d.status = STAT_EMPTY;
              end else begin
                pend_valid_d = pend_valid_q && !out_free;
                walk_d       = front_q;
                left_d       = count_q;
                state_d      = ST_LIST;
              end
            end
            default: begin
              pend_valid_d = pend_valid_q && !out_free;
            end
          endcase
        end
      end
      ST_LIST: begin
        if (advance) begin
          mem_addr        = walk_q;
          mem_re          = 1'b1;
          pend_valid_d    = 1'b1;
          pend_d.from_mem = 1'b1;
          pend_d.status   = STAT_OK;
          pend_d.last     = (left_q == CNT_W'(1));
          walk_d          = ring_add(walk_q, CNT_W'(1));
          left_d          = left_q - CNT_W'(1);
          if (left_q == CNT_W'(1)) begin
            state_d = ST_CMD;
          end
        end
      end
      default: begin
        state_d = ST_CMD;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CMD;
      front_q      <= '0;
      count_q      <= '0;
      walk_q       <= '0;
      left_q       <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      front_q      <= front_d;
      count_q      <= count_d;
      walk_q       <= walk_d;
      left_q       <= left_d;
      pend_valid_q <= pend_valid_d;
      if (pend_valid_q && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // pending result and output payload
  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    if (pend_valid_q && out_free) begin
      out_data_q <= pend_q.from_mem ? rd_data_q : '0;
      out_stat_q <= pend_q.status;
      out_last_q <= pend_q.last;
    end
  end

  // ring store, single port, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= cmd_i.value;
    end
    if (mem_re) begin
      rd_data_q <= mem[mem_addr];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_stat_q;
  assign m_axis_tlast_o  = out_last_q;

  // checks
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_pend_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_valid_q && !out_free) |=> pend_valid_q)
    else $error("pending result lost while output stalled");

  a_list_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LIST) |-> (left_q != '0 && count_q != '0))
    else $error("listing walk with nothing left");

  a_list_no_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LIST) |-> !cmd_ready_o)
    else $error("command taken during a listing");

endmodule

`default_nettype wire

>>> design/bounded_deque.sv
// ----------------------------------------------------------------------------
// bounded_deque: double-ended queue of signed 32-bit values
// Ring store of DEPTH entries with push and pop at both ends and a listing
// of all entries from front to back.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request per item: tuser is the action (0 push front,
//   1 push back, 2 pop front, 3 pop back, 4 list), tdata the value to push.
//   Actions 5 to 7 are taken and ignored.
//   m_axis returns the results: tdata the popped or listed value (zero
//   otherwise), tuser the status (0 ok, 1 empty, 2 full and push dropped),
//   tlast high on the final result of a request.
//   A request passes through the command queue, then the pending result
//   and store read registers, then the output register.
//   Push and pop use the store port once each; a listing of n entries
//   first starts the walk and then walks the store, one store read and
//   one result per entry; new commands wait while a listing runs.
//   A two-entry command queue separates the input from the store side, so
//   requests are still taken while a result waits on a stalled receiver;
//   once the queue fills, s_axis_tready_o drops until results drain.
//   Reset empties the queue; the store itself is not cleared and is only
//   read at occupied entries.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bounded_deque #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  wire logic [bdq_pkg::DATA_W-1:0] s_axis_tdata_i,  // value_in[31:0]
  input  wire logic [bdq_pkg::ACT_W-1:0]  s_axis_tuser_i,  // action[2:0]
  output logic                            m_axis_tvalid_o,
  input  wire logic                       m_axis_tready_i,
  output logic [bdq_pkg::DATA_W-1:0]      m_axis_tdata_o,  // value_out[31:0]
  output logic [bdq_pkg::STAT_W-1:0]      m_axis_tuser_o,  // status[1:0]
  output logic                            m_axis_tlast_o
);

  import bdq_pkg::*;

  logic q_full, q_push, q_valid, q_pop;
  cmd_t q_in, q_out;

  // decode requests
  bdq_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_cmd_o         (q_in)
  );

  // queue commands between the two sides
  bdq_cmd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_in),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .data_o      (q_out)
  );

  // carry out commands on the store
  bdq_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (q_valid),
    .cmd_i           (q_out),
    .cmd_ready_o     (q_pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

`default_nettype wire

>>> sim/tb_bounded_deque.sv
// ----------------------------------------------------------------------------
// tb_bounded_deque: self-checking testbench of the bounded deque
// Drives request items on s_axis and checks every result item on m_axis
// against the directed table or an in-bench deque predictor. The table covers
// the empty and full cases, the value extremes and a reserved action. Random
// phases that lean towards filling or draining follow. Both sides idle in
// random bursts. The receiver holds off once for a long stretch and the
// sender pauses once until every result has come back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_bounded_deque;
  import bdq_pkg::*;

  localparam int unsigned DEPTH       = 16;
  localparam int          RAND_ITEMS  = 285;
  localparam int          QUIET_ITEMS = 40;
  localparam int          PAUSE_AT    = 150;
  localparam int          HOLD_AT     = 80;
  localparam int          LONG_HOLD   = 400;
  localparam int          DRAIN_MAX   = 20000;
  localparam int          N_DIR       = 25;

  // reserved action codes, taken and ignored by the block
  localparam logic [ACT_W-1:0] ACT_RSVD5 = 3'd5;
  localparam logic [ACT_W-1:0] ACT_RSVD6 = 3'd6;
  localparam logic [ACT_W-1:0] ACT_RSVD7 = 3'd7;

  // how the results of an item are obtained
  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_NONE,
    CHK_ONE
  } chk_e;

  typedef struct packed {
    logic [ACT_W-1:0]  act;
    logic [DATA_W-1:0] val;
    chk_e              chk;
    stat_e             stat;
  } stim_row_t;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    stat_e             status;
    logic              last;
  } result_t;

  // directed table: typed results only for push acknowledgements, empty and full
  stim_row_t dir_tab [N_DIR] = '{
    '{ACT_POP_FRONT,  32'h0000_0000, CHK_ONE,   STAT_EMPTY},
    '{ACT_POP_BACK,   32'h0000_0000, CHK_ONE,   STAT_EMPTY},
    '{ACT_LIST,       32'h0000_0000, CHK_ONE,   STAT_EMPTY},
    '{ACT_RSVD6,      32'h1234_5678, CHK_NONE,  STAT_OK},
    '{ACT_PUSH_BACK,  32'h7FFF_FFFF, CHK_ONE,   STAT_OK},
    '{ACT_PUSH_FRONT, 32'h8000_0000, CHK_ONE,   STAT_OK},
    '{ACT_PUSH_BACK,  32'h0000_0000, CHK_ONE,   STAT_OK},
    '{ACT_PUSH_FRONT, 32'hFFFF_FFFF, CHK_ONE,   STAT_OK},
    '{ACT_PUSH_BACK,  32'h5555_5555, CHK_ONE,   STAT_OK},
    '{ACT_PUSH_FRONT, 32'hAAAA_AAAA, CHK_ONE,   STAT_OK},
    '{ACT_PUSH_BACK,  32'h0000_0001, CHK_ONE,   STAT_OK},
    '{ACT_PUSH_FRONT, 32'hFFFF_FFFE, CHK_ONE,   STAT_OK},
    '{ACT_PUSH_BACK,  32'h0F0F_0F0F, CHK_ONE,   STAT_OK},
    '{ACT_PUSH_FRONT, 32'hF0F0_F0F0, CHK_ONE,   STAT_OK},
    '{ACT_PUSH_BACK,  32'h00FF_00FF, CHK_ONE,   STAT_OK},
    '{ACT_PUSH_FRONT, 32'hFF00_FF00, CHK_ONE,   STAT_OK},
    '{ACT_PUSH_BACK,  32'h0000_FFFF, CHK_ONE,   STAT_OK},
    '{ACT_PUSH_FRONT, 32'hFFFF_0000, CHK_ONE,   STAT_OK},
    '{ACT_PUSH_BACK,  32'h1357_9BDF, CHK_ONE,   STAT_OK},
    '{ACT_PUSH_FRONT, 32'hECA8_6420, CHK_ONE,   STAT_OK},
    '{ACT_PUSH_BACK,  32'h0000_0000, CHK_ONE,   STAT_FULL},
    '{ACT_PUSH_FRONT, 32'h7FFF_FFFF, CHK_ONE,   STAT_FULL},
    '{ACT_LIST,       32'h0000_0000, CHK_MODEL, STAT_OK},
    '{ACT_POP_FRONT,  32'h0000_0000, CHK_MODEL, STAT_OK},
    '{ACT_POP_BACK,   32'h0000_0000, CHK_MODEL, STAT_OK}
  };

  logic [ACT_W-1:0]  rsvd_codes [3] = '{ACT_RSVD5, ACT_RSVD6, ACT_RSVD7};
  logic [DATA_W-1:0] edge_vals  [4] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF};

  // clock, reset and block inputs
  logic              clk_i     = 1'b0;
  logic              rst_ni    = 1'b0;
  logic              s_tvalid  = 1'b0;
  logic [DATA_W-1:0] s_tdata   = '0;
  logic [ACT_W-1:0]  s_tuser   = '0;
  logic              m_tready  = 1'b0;
  chk_e              item_chk  = CHK_MODEL;
  stat_e             item_stat = STAT_OK;

  logic              s_axis_tready_o;
  logic              m_axis_tvalid_o;
  logic [DATA_W-1:0] m_axis_tdata_o;
  logic [STAT_W-1:0] m_axis_tuser_o;
  logic              m_axis_tlast_o;

  // deque predictor state
  logic [DATA_W-1:0] dq_mem [DEPTH];
  logic [3:0]        dq_front = '0;
  logic [4:0]        dq_count = '0;

  result_t step_results [$];
  result_t awaited_results [$];
  int      rx_cnt  = 0;
  int      err_cnt = 0;
  bit      quiet   = 1'b0;

  bounded_deque #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_tdata),         // value_in[31:0]
    .s_axis_tuser_i (s_tuser),         // action[2:0]
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_axis_tdata_o),  // value_out[31:0]
    .m_axis_tuser_o (m_axis_tuser_o),  // status[1:0]
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  always #2 clk_i = ~clk_i;

  // hold reset low at the start, then release it
  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // stop a hung run
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // apply one request to the predicted deque and collect its results
  task automatic deque_step(input logic [ACT_W-1:0] act, input logic [DATA_W-1:0] val);
    logic [3:0] idx;
    begin
      case (act)
        ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
          if (dq_count == DEPTH) begin
            step_results.push_back(result_t'{value: '0, status: STAT_FULL, last: 1'b1});
          end else begin
            if (act == ACT_PUSH_FRONT) begin
              dq_front = dq_front - 4'd1;
              dq_mem[dq_front] = val;
            end else begin
              idx = dq_front + dq_count[3:0];
              dq_mem[idx] = val;
            end
            dq_count = dq_count + 5'd1;
            step_results.push_back(result_t'{value: '0, status: STAT_OK, last: 1'b1});
          end
        end
        ACT_POP_FRONT, ACT_POP_BACK: begin
          if (dq_count == 0) begin
            step_results.push_back(result_t'{value: '0, status: STAT_EMPTY, last: 1'b1});
          end else begin
            if (act == ACT_POP_FRONT) begin
              idx = dq_front;
              dq_front = dq_front + 4'd1;
            end else begin
              idx = dq_front + dq_count[3:0] - 4'd1;
            end
            dq_count = dq_count - 5'd1;
            step_results.push_back(result_t'{value: dq_mem[idx], status: STAT_OK,
                                             last: 1'b1});
          end
        end
        ACT_LIST: begin
          if (dq_count == 0) begin
            step_results.push_back(result_t'{value: '0, status: STAT_EMPTY, last: 1'b1});
          end else begin
            for (int i = 0; i < dq_count; i++) begin
              idx = dq_front + i[3:0];
              step_results.push_back(result_t'{value: dq_mem[idx], status: STAT_OK,
                                               last: (i == dq_count - 1)});
            end
          end
        end
        default: ;
      endcase
    end
  endtask

  // predict on every accepted request, check every accepted result
  always @(posedge clk_i) begin
    result_t want;
    if (s_tvalid && s_axis_tready_o) begin
      step_results.delete();
      deque_step(s_tuser, s_tdata);
      case (item_chk)
        CHK_ONE:   awaited_results.push_back(result_t'{value: '0, status: item_stat,
                                                       last: 1'b1});
        CHK_MODEL: foreach (step_results[k]) awaited_results.push_back(step_results[k]);
        default:   ;
      endcase
    end
    if (m_axis_tvalid_o && m_tready) begin
      rx_cnt++;
      if (awaited_results.size() == 0) begin
        $error("unexpected result: value_out %h status %0d last %0b",
               m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
        err_cnt++;
      end else begin
        want = awaited_results.pop_front();
        if (m_axis_tdata_o !== want.value) begin
          $error("value_out: expected %h, got %h", want.value, m_axis_tdata_o);
          err_cnt++;
        end
        if (m_axis_tuser_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_axis_tuser_o);
          err_cnt++;
        end
        if (m_axis_tlast_o !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, m_axis_tlast_o);
          err_cnt++;
        end
      end
    end
  end

  // offer one request item and hold it until taken, then maybe idle
  task automatic send_item(input logic [ACT_W-1:0] act, input logic [DATA_W-1:0] val,
                           input chk_e chk, input stat_e stat);
    begin
      s_tvalid  <= 1'b1;
      s_tdata   <= val;
      s_tuser   <= act;
      item_chk  <= chk;
      item_stat <= stat;
      do @(posedge clk_i); while (!s_axis_tready_o);
      if (!quiet && $urandom_range(0, 4) == 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end
    end
  endtask

  // receiver: random stalls, one long hold-off
  initial begin
    bit held;
    held = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (!held && rx_cnt >= HOLD_AT) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      @(posedge clk_i);
    end
  end

  // sender: directed table, random phases, drain and verdict
  initial begin
    int               done_cnt;
    int               mood;
    int               roll;
    int               waited;
    bit               paused;
    bit               is_rsvd;
    logic [ACT_W-1:0] act;
    logic [DATA_W-1:0] val;

    done_cnt = 0;
    mood     = 2;
    paused   = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);

    foreach (dir_tab[r]) send_item(dir_tab[r].act, dir_tab[r].val, dir_tab[r].chk,
                                   dir_tab[r].stat);

    while (done_cnt < RAND_ITEMS) begin
      // swap between filling, draining and balanced phases
      if (done_cnt % 30 == 0) mood = $urandom_range(0, 2);
      quiet = (done_cnt >= RAND_ITEMS - QUIET_ITEMS);

      // pause until every awaited result is back
      if (done_cnt == PAUSE_AT && !paused) begin
        paused = 1'b1;
        s_tvalid <= 1'b0;
        do @(posedge clk_i); while (awaited_results.size() != 0);
      end

      is_rsvd = ($urandom_range(0, 99) < 4);
      roll    = $urandom_range(0, 99);
      if (is_rsvd) begin
        act = rsvd_codes[$urandom_range(0, 2)];
      end else if (roll < (mood == 0 ? 70 : (mood == 1 ? 20 : 45))) begin
        act = $urandom_range(0, 1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
      end else if (roll < (mood == 2 ? 88 : 90)) begin
        act = $urandom_range(0, 1) ? ACT_POP_BACK : ACT_POP_FRONT;
      end else begin
        act = ACT_LIST;
      end
      val = ($urandom_range(0, 7) == 0) ? edge_vals[$urandom_range(0, 3)] : $urandom;

      send_item(act, val, CHK_MODEL, STAT_OK);
      if (!is_rsvd) done_cnt++;
    end

    // drain all results, then allow for stray ones
    s_tvalid <= 1'b0;
    quiet = 1'b1;
    waited = 0;
    do begin
      @(posedge clk_i);
      waited++;
    end while (awaited_results.size() != 0 && waited < DRAIN_MAX);
    repeat (2 * DEPTH) @(posedge clk_i);
    if (awaited_results.size() != 0) begin
      $error("%0d awaited results never arrived", awaited_results.size());
      err_cnt++;
    end

    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
